[rtl/core/flash_update_stream_parser_unit_macros.svh]
// ----------------------------------------------------------------------------
// Flash update stream parser assertion macros
// Shared property shapes for the concurrent checks of the parser top level.
// ----------------------------------------------------------------------------
`ifndef FLASH_UPDATE_STREAM_PARSER_UNIT_MACROS_SVH
`define FLASH_UPDATE_STREAM_PARSER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FUSP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FUSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/fusp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flash update stream parser package
// Widths, codes and the job record passed from the front end to the back end.
// ----------------------------------------------------------------------------
package fusp_pkg;

    localparam int MAX_PAGE_BYTES = 4096;
    localparam int MIN_PAGE_BYTES = 2;

    localparam int PAGE_BYTES_W = 13;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 16;

    // Parser stages
    localparam logic [1:0] STAGE_HUNT = 2'd0;
    localparam logic [1:0] STAGE_LEN  = 2'd1;
    localparam logic [1:0] STAGE_DATA = 2'd2;

    // Command kinds
    localparam logic [1:0] KIND_ERASE = 2'd0;
    localparam logic [1:0] KIND_FILL  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;
    localparam logic [1:0] KIND_APPLY = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_START_WORD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PAGE_BYTES = 2'd1;

    // Job queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // One completed data word and the commands it calls for.
    typedef struct packed {
        logic        erase;
        logic        write;
        logic        apply;
        logic [15:0] page;
        logic [31:0] offset;
        logic [15:0] word;
    } fusp_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fusp_qstat_t;

endpackage

[rtl/core/fusp_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flash update stream parser front end
// Hunts for the start word, gathers the length and data words, and queues
// one job per completed data word.
// ----------------------------------------------------------------------------
module fusp_front
    import fusp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [7:0]              data_byte,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [15:0]             start_word,
    input  logic [PAGE_BYTES_W-1:0] page_bytes,
    input  fusp_qstat_t             qstat,
    output logic                    push,
    output fusp_job_t               job
);

    logic [1:0]              stage_reg,       stage_next;
    logic [1:0]              sub_count_reg,   sub_count_next;
    logic [7:0]              hold_reg,        hold_next;
    logic [31:0]             total_reg,       total_next;
    logic [31:0]             bytes_done_reg,  bytes_done_next;
    logic [PAGE_BYTES_W-1:0] page_fill_reg,   page_fill_next;
    logic [15:0]             page_number_reg, page_number_next;

    logic                    accept;
    logic [PAGE_BYTES_W-1:0] size;
    logic [PAGE_BYTES_W-1:0] fill_inc;
    logic                    page_full;
    logic [32:0]             done;
    logic                    finish;

    assign in_ready = !qstat.full;
    assign accept   = in_valid && in_ready;

    // Page size clamped to the legal range.
    always_comb
    begin
        if (page_bytes < PAGE_BYTES_W'(MIN_PAGE_BYTES))
            size = PAGE_BYTES_W'(MIN_PAGE_BYTES);
        else if (page_bytes > PAGE_BYTES_W'(MAX_PAGE_BYTES))
            size = PAGE_BYTES_W'(MAX_PAGE_BYTES);
        else
            size = page_bytes;
    end

    assign fill_inc  = page_fill_reg + PAGE_BYTES_W'(2);
    assign page_full = (fill_inc >= size);
    assign done      = {1'b0, bytes_done_reg} + 33'd2;
    assign finish    = (done >= {1'b0, total_reg});

    always_comb
    begin
        stage_next       = stage_reg;
        sub_count_next   = sub_count_reg;
        hold_next        = hold_reg;
        total_next       = total_reg;
        bytes_done_next  = bytes_done_reg;
        page_fill_next   = page_fill_reg;
        page_number_next = page_number_reg;
        push             = 1'b0;

        job.erase  = (page_fill_reg == '0);
        job.write  = page_full;
        job.apply  = finish;
        job.page   = page_number_reg;
        job.offset = bytes_done_reg;
        job.word   = {hold_reg, data_byte};

        if (accept)
        begin
            unique case (stage_reg)
                STAGE_LEN:
                begin
                    total_next = total_reg | ({24'd0, data_byte} << {sub_count_reg, 3'b000});
                    if (sub_count_reg == 2'd3)
                    begin
                        sub_count_next = 2'd0;
                        stage_next     = STAGE_DATA;
                    end
                    else
                    begin
                        sub_count_next = sub_count_reg + 2'd1;
                    end
                end
                STAGE_DATA:
                begin
                    if (sub_count_reg == 2'd0)
                    begin
                        hold_next      = data_byte;
                        sub_count_next = 2'd1;
                    end
                    else
                    begin
                        push            = 1'b1;
                        sub_count_next  = 2'd0;
                        bytes_done_next = done[31:0];
                        if (page_full)
                        begin
                            page_fill_next   = '0;
                            page_number_next = page_number_reg + 16'd1;
                        end
                        else
                        begin
                            page_fill_next = fill_inc;
                        end
                        if (finish)
                        begin
                            stage_next       = STAGE_HUNT;
                            hold_next        = 8'd0;
                            total_next       = 32'd0;
                            bytes_done_next  = 32'd0;
                            page_fill_next   = '0;
                            page_number_next = 16'd0;
                        end
                    end
                end
                default:
                begin
                    stage_next = STAGE_HUNT;
                    if (sub_count_reg == 2'd0)
                    begin
                        if (data_byte == start_word[7:0])
                            sub_count_next = 2'd1;
                    end
                    else
                    begin
                        sub_count_next = 2'd0;
                        if (data_byte == start_word[15:8])
                        begin
                            stage_next       = STAGE_LEN;
                            hold_next        = 8'd0;
                            total_next       = 32'd0;
                            bytes_done_next  = 32'd0;
                            page_fill_next   = '0;
                            page_number_next = 16'd0;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg       <= STAGE_HUNT;
            sub_count_reg   <= 2'd0;
            hold_reg        <= 8'd0;
            total_reg       <= 32'd0;
            bytes_done_reg  <= 32'd0;
            page_fill_reg   <= '0;
            page_number_reg <= 16'd0;
        end
        else
        begin
            stage_reg       <= stage_next;
            sub_count_reg   <= sub_count_next;
            hold_reg        <= hold_next;
            total_reg       <= total_next;
            bytes_done_reg  <= bytes_done_next;
            page_fill_reg   <= page_fill_next;
            page_number_reg <= page_number_next;
        end
    end

endmodule

[rtl/core/fusp_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flash update stream parser job queue
// Small first-in first-out buffer of jobs between the front and back ends.
// ----------------------------------------------------------------------------
module fusp_queue
    import fusp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  fusp_job_t   push_job,
    input  logic        pop,
    output fusp_job_t   head_job,
    output fusp_qstat_t qstat
);

    fusp_job_t             entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]     count_reg,  count_next;

    assign qstat.full  = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign head_job    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/core/fusp_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flash update stream parser back end
// Expands each queued job into its flash commands, one per cycle while the
// consumer takes them, through an output register.
// ----------------------------------------------------------------------------
module fusp_back
    import fusp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  fusp_job_t   head_job,
    input  fusp_qstat_t qstat,
    output logic        pop,
    output logic [1:0]  cmd_kind,
    output logic [15:0] page_index,
    output logic [31:0] byte_offset,
    output logic [15:0] word_value,
    output logic        last,
    output logic        out_valid,
    input  logic        out_ready
);

    // Pending commands of the current job: bit 0 erase, 1 fill, 2 write, 3 apply.
    logic [3:0]  mask_reg,      mask_next;
    fusp_job_t   job_reg,       job_next;
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  kind_reg,      kind_next;
    logic [15:0] page_reg,      page_next;
    logic [31:0] offset_reg,    offset_next;
    logic [15:0] word_reg,      word_next;
    logic        last_reg,      last_next;

    logic        can_emit;
    logic        emit;
    logic [3:0]  pick;
    logic [3:0]  rest;
    logic        load;

    assign can_emit = !out_valid_reg || out_ready;
    assign emit     = can_emit && (mask_reg != 4'd0);
    assign pick     = mask_reg & (~mask_reg + 4'd1);
    assign rest     = mask_reg & ~pick;
    assign load     = !qstat.empty && ((mask_reg == 4'd0) || (emit && (rest == 4'd0)));
    assign pop      = load;

    always_comb
    begin
        job_next       = job_reg;
        mask_next      = mask_reg;
        out_valid_next = emit || (out_valid_reg && !out_ready);
        kind_next      = kind_reg;
        page_next      = page_reg;
        offset_next    = offset_reg;
        word_next      = word_reg;
        last_next      = last_reg;

        if (emit)
        begin
            mask_next   = rest;
            page_next   = 16'd0;
            offset_next = 32'd0;
            word_next   = 16'd0;
            last_next   = (rest == 4'd0);
            unique case (pick)
                4'b0001:
                begin
                    kind_next = KIND_ERASE;
                    page_next = job_reg.page;
                end
                4'b0010:
                begin
                    kind_next   = KIND_FILL;
                    offset_next = job_reg.offset;
                    word_next   = job_reg.word;
                end
                4'b0100:
                begin
                    kind_next = KIND_WRITE;
                    page_next = job_reg.page;
                end
                default:
                begin
                    kind_next = KIND_APPLY;
                end
            endcase
        end

        if (load)
        begin
            job_next  = head_job;
            mask_next = {head_job.apply, head_job.write, 1'b1, head_job.erase};
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg    <= job_next;
        kind_reg   <= kind_next;
        page_reg   <= page_next;
        offset_reg <= offset_next;
        word_reg   <= word_next;
        last_reg   <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign cmd_kind    = kind_reg;
    assign page_index  = page_reg;
    assign byte_offset = offset_reg;
    assign word_value  = word_reg;
    assign last        = last_reg;

endmodule

[rtl/core/flash_update_stream_parser_unit.sv]
// Path: job queue, then back-end job register, then command output register.
// Throughput: one byte per cycle while the four-entry job queue has room; the back end
// issues one command per cycle while out_ready allows, and a word needs one to four commands.
// Reset: asynchronous, active low; the parser returns to hunting, the queue empties,
// start_word clears to 0 and page_bytes returns to 128.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flash update stream parser
// Turns a byte stream of a firmware update into erase, fill, write and apply
// flash commands.
// ----------------------------------------------------------------------------
`include "flash_update_stream_parser_unit_macros.svh"

module flash_update_stream_parser_unit
    import fusp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Configuration write port
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    // Byte input channel
    input  logic [7:0]             data_byte,
    input  logic                   in_valid,
    output logic                   in_ready,
    // Command output channel
    output logic [1:0]             cmd_kind,
    output logic [15:0]            page_index,
    output logic [31:0]            byte_offset,
    output logic [15:0]            word_value,
    output logic                   last,
    output logic                   out_valid,
    input  logic                   out_ready
);

    // Configuration registers. They are to be written only while the parser is
    // idle (the block does not enforce it), so no shadowing is needed.
    logic [15:0]             start_word_reg;
    logic [PAGE_BYTES_W-1:0] page_bytes_reg;

    // Front end to queue, queue to back end.
    logic        q_push;
    fusp_job_t   q_push_job;
    logic        q_pop;
    fusp_job_t   q_head_job;
    fusp_qstat_t q_stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_word_reg <= 16'd0;
            page_bytes_reg <= PAGE_BYTES_W'(128);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_START_WORD: start_word_reg <= cfg_wdata;
                REG_PAGE_BYTES: page_bytes_reg <= cfg_wdata[PAGE_BYTES_W-1:0];
                default:
                begin
                    start_word_reg <= start_word_reg;
                end
            endcase
        end
    end

    // The front end takes one byte per transfer and, on the second byte of
    // a data word, queues a job that records which commands the word needs.
    fusp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_byte  (data_byte),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .start_word (start_word_reg),
        .page_bytes (page_bytes_reg),
        .qstat      (q_stat),
        .push       (q_push),
        .job        (q_push_job)
    );

    // The queue decouples byte intake from command issue, so a stalled
    // command consumer does not stop bytes until the queue fills.
    fusp_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_push_job),
        .pop      (q_pop),
        .head_job (q_head_job),
        .qstat    (q_stat)
    );

    // The back end walks the commands of each job in order and hands each
    // one out as a transfer on the output channel.
    fusp_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_job    (q_head_job),
        .qstat       (q_stat),
        .pop         (q_pop),
        .cmd_kind    (cmd_kind),
        .page_index  (page_index),
        .byte_offset (byte_offset),
        .word_value  (word_value),
        .last        (last),
        .out_valid   (out_valid),
        .out_ready   (out_ready)
    );

    // A job is never pushed into a full queue.
    `FUSP_ASSERT_SAME(a_no_push_when_full, q_push, !q_stat.full, "job pushed into full queue")
    // Apply always closes the commands of a word.
    `FUSP_ASSERT_SAME(a_apply_is_last, out_valid && (cmd_kind == KIND_APPLY), last,
        "apply command without last")
    // An erase is always followed by the fill of the same word.
    `FUSP_ASSERT_SAME(a_erase_not_last, out_valid && (cmd_kind == KIND_ERASE), !last,
        "erase command marked last")
    // Commands of one word leave back to back once the consumer takes them.
    `FUSP_ASSERT_NEXT(a_word_no_gap, out_valid && out_ready && !last, out_valid,
        "gap inside the commands of one word")

endmodule
